[rtl/core/acctilt_pkg.sv]
`default_nettype none
package acctilt_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STAGES   = 16;
    localparam int TABLE_LEN       = 24;
    localparam int INNER_FRAC      = 16;

    // sum of squares of two 16-bit values, up to 2^31
    localparam int SUM_W  = 32;
    // root of sum << 16 fits in 24 bits
    localparam int ROOT_W = 24;
    // one result bit per root stage
    localparam int ROOT_STAGES = 24;
    // cordic x/y working width: magnitude grows by about 1.65
    localparam int XY_W   = 28;
    // angle accumulator, degrees * 2^16, signed
    localparam int Z_W    = 26;
    localparam int ANG_W  = 16;

    typedef logic signed [15:0] t_axis;

    // atan(2^-i) in degrees * 2^16
    function automatic logic [22:0] atan_deg(input logic [4:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/core/accel_tilt_angles.sv]
`default_nettype none
// accelerometer tilt angles
// s_axis request: six bytes of one sample; m_axis request: three angles and
// a degenerate flag. three lanes (pitch, roll, elevation) run in parallel,
// each a squares stage, a sum stage, a 24-stage pipelined square root,
// a vectoring cordic of CORDIC_STAGES stages (at most TABLE_LEN) and a
// rounding output register; their output registers drive m_axis_tdata.
// throughput: one sample per cycle while the receiver does not stall.
// the whole pipe advances when the output register is empty or taken, so
// a stalled receiver holds every stage and s_axis_tready drops; a new
// sample is still taken in the cycle the output is taken.
// reset clears the valid bits only; no clearing pass is needed.
// angles are degrees * 2^ANGLE_FRAC_BITS, signed 16-bit, saturated at 90.
module accel_tilt_angles #(
    parameter int ANGLE_FRAC_BITS = acctilt_pkg::ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = acctilt_pkg::CORDIC_STAGES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x_high, x_low, y_high, y_low, z_high, z_low from bit 0 up
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pitch_angle, roll_angle, elevation_angle, degenerate, zero pad
    output logic [55:0]      m_axis_tdata
);
    localparam int NSTG = (CORDIC_STAGES < acctilt_pkg::TABLE_LEN) ?
                          CORDIC_STAGES : acctilt_pkg::TABLE_LEN;
    localparam int LAT  = 2 + acctilt_pkg::ROOT_STAGES + NSTG + 1;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    acctilt_pkg::t_axis ax, ay, az;
    assign ax = {s_axis_tdata[7:0],   s_axis_tdata[15:8]};
    assign ay = {s_axis_tdata[23:16], s_axis_tdata[31:24]};
    assign az = {s_axis_tdata[39:32], s_axis_tdata[47:40]};

    // valid and degenerate shift line
    logic [LAT-1:0] r_vld, r_dgn;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dgn <= {r_dgn[LAT-2:0], (ax == '0) && (ay == '0) && (az == '0)};
        end
    end

    logic [15:0] ang_x, ang_y, ang_z;
    acctilt_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES))
        u_lane_x (.i_clk, .i_en(en), .i_a(ax), .i_b(ay), .i_c(az), .o_angle(ang_x));
    acctilt_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES))
        u_lane_y (.i_clk, .i_en(en), .i_a(ay), .i_b(ax), .i_c(az), .o_angle(ang_y));
    acctilt_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES))
        u_lane_z (.i_clk, .i_en(en), .i_a(az), .i_b(ax), .i_c(ay), .o_angle(ang_z));

    // merge: the lane output registers are the output stage
    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata  = {7'd0, r_dgn[LAT-1], ang_z, ang_y, ang_x};
endmodule
`default_nettype wire

[rtl/core/acctilt_lane.sv]
`default_nettype none
// one tilt lane: squares, pipelined root, pipelined cordic, rounding
module acctilt_lane #(
    parameter int ANGLE_FRAC_BITS = acctilt_pkg::ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = acctilt_pkg::CORDIC_STAGES,
    localparam int NSTG = (CORDIC_STAGES < acctilt_pkg::TABLE_LEN) ?
                          CORDIC_STAGES : acctilt_pkg::TABLE_LEN,
    localparam int LAT  = 2 + acctilt_pkg::ROOT_STAGES + NSTG + 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [15:0]  i_a,
    input  wire logic signed [15:0]  i_b,
    input  wire logic signed [15:0]  i_c,
    output logic [15:0]              o_angle
);
    localparam int SW = acctilt_pkg::SUM_W;
    localparam int RW = acctilt_pkg::ROOT_W;
    localparam int RS = acctilt_pkg::ROOT_STAGES;
    localparam int XW = acctilt_pkg::XY_W;
    localparam int ZW = acctilt_pkg::Z_W;
    localparam int K  = acctilt_pkg::INNER_FRAC - ANGLE_FRAC_BITS;
    localparam int RADW = 48;
    localparam logic [ZW-1:0] LIMIT = ZW'(90 << ANGLE_FRAC_BITS);

    // side info carried down the pipe
    typedef struct packed {
        logic        neg;
        logic        zero_a;
        logic        zero_s;
        logic [15:0] mag;
    } t_side;

    // stage 0: squares
    logic [SW-1:0] r_sb, r_sc;
    t_side r_side0;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb <= $unsigned(32'(i_b) * 32'(i_b));
            r_sc <= $unsigned(32'(i_c) * 32'(i_c));
            r_side0.neg    <= i_a[15];
            r_side0.zero_a <= (i_a == '0);
            r_side0.zero_s <= 1'b0;
            r_side0.mag    <= i_a[15] ? 16'(-i_a) : 16'(i_a);
        end
    end

    // stage 1: sum
    logic [SW-1:0] r_sum;
    t_side r_side1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= r_sb + r_sc;
            r_side1 <= '{neg:    r_side0.neg,
                         zero_a: r_side0.zero_a,
                         zero_s: (r_sb == '0) && (r_sc == '0),
                         mag:    r_side0.mag};
        end
    end

    // root pipeline, one result bit per stage on sum << 16
    logic [RADW-1:0] r_rem [0:RS];
    logic [RW-1:0]   r_res [0:RS];
    t_side           r_rs  [0:RS];
    assign r_rem[0] = {r_sum, 16'd0};
    assign r_res[0] = '0;
    assign r_rs[0]  = r_side1;
    for (genvar g = 0; g < RS; g++) begin : g_root
        logic [RADW-1:0] trial, chunk, rem_sh;
        logic [RADW-1:0] n_rem;
        logic [RW-1:0]   n_res;
        always_comb begin
            rem_sh = r_rem[g];
            trial  = RADW'({r_res[g], 2'b01});
            chunk  = (rem_sh >> (2 * (RS - 1 - g)));
            if (chunk >= trial) begin
                n_rem = rem_sh - (trial << (2 * (RS - 1 - g)));
                n_res = {r_res[g][RW-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_res = {r_res[g][RW-2:0], 1'b0};
            end
        end
        logic [RADW-1:0] r_q_rem;
        logic [RW-1:0]   r_q_res;
        t_side           r_q_s;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q_rem <= n_rem;
                r_q_res <= n_res;
                r_q_s   <= r_rs[g];
            end
        end
        assign r_rem[g+1] = r_q_rem;
        assign r_res[g+1] = r_q_res;
        assign r_rs[g+1]  = r_q_s;
    end

    // cordic vectoring stages
    logic signed [XW-1:0] r_x [0:NSTG];
    logic signed [XW-1:0] r_y [0:NSTG];
    logic signed [ZW-1:0] r_z [0:NSTG];
    t_side                r_cs [0:NSTG];
    assign r_x[0]  = XW'(r_res[RS]);
    assign r_y[0]  = XW'({r_rs[RS].mag, 8'd0});
    assign r_z[0]  = '0;
    assign r_cs[0] = r_rs[RS];
    for (genvar s = 0; s < NSTG; s++) begin : g_cordic
        logic signed [XW-1:0] xs, ys, r_xq, r_yq;
        logic signed [ZW-1:0] t, r_zq;
        t_side r_sq;
        assign xs = r_x[s] >>> s;
        assign ys = r_y[s] >>> s;
        assign t  = ZW'(acctilt_pkg::atan_deg(5'(s)));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[s] > 0) begin
                    r_xq <= r_x[s] + ys;
                    r_yq <= r_y[s] - xs;
                    r_zq <= r_z[s] + t;
                end else begin
                    r_xq <= r_x[s] - ys;
                    r_yq <= r_y[s] + xs;
                    r_zq <= r_z[s] - t;
                end
                r_sq <= r_cs[s];
            end
        end
        assign r_x[s+1]  = r_xq;
        assign r_y[s+1]  = r_yq;
        assign r_z[s+1]  = r_zq;
        assign r_cs[s+1] = r_sq;
    end

    // round, saturate, sign
    logic [ZW-1:0] zc, mag, mags;
    always_comb begin
        zc  = r_z[NSTG][ZW-1] ? '0 : r_z[NSTG];
        mag = (zc + ZW'((1 << K) >> 1)) >> K;
        if (mag > LIMIT || r_cs[NSTG].zero_s) mags = LIMIT;
        else                                   mags = mag;
        if (r_cs[NSTG].zero_a) mags = '0;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= r_cs[NSTG].neg ? 16'(-mags) : 16'(mags);
        end
    end

    logic unused;
    assign unused = ^{r_x[NSTG], r_y[NSTG], LAT};
endmodule
`default_nettype wire

[rtl/core/acctilt_checker.sv]
`default_nettype none
// port-level checks for the tilt block
module acctilt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // ready follows the output register
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");
    // degenerate result has zero angles
    a_dgn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[48] |-> m_axis_tdata[47:0] == '0)
        else $error("degenerate with nonzero angle");
    // nothing out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind accel_tilt_angles acctilt_checker u_chk (.*);
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;

    // tilt result of one sample
    typedef struct packed {
        logic        degenerate;
        logic [15:0] elevation;
        logic [15:0] roll;
        logic [15:0] pitch;
    } t_tilt;

    localparam int RAND_SAMPLES = 1400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LATENCY      = acctilt_pkg::CORDIC_STAGES + 27;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // x_high, x_low, y_high, y_low, z_high, z_low from bit 0 up
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // pitch_angle, roll_angle, elevation_angle, degenerate, zero pad
    logic [55:0] m_axis_tdata;

    t_tilt  pending_angles[$];
    int     mismatch_cnt;
    int     idle_cycles;
    bit     hold_recv;

    accel_tilt_angles u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // integer square root, floor
    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // one axis angle by vectoring cordic, degrees * 2^8
    function automatic logic [15:0] axis_angle(input int a, input int b, input int c);
        longint          lim;
        longint          mag;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        longint unsigned sq;
        int              k;
        lim = longint'(90) << acctilt_pkg::ANGLE_FRAC_BITS;
        k   = acctilt_pkg::INNER_FRAC - acctilt_pkg::ANGLE_FRAC_BITS;
        if (a == 0) return 16'd0;
        sq = longint'(b) * b + longint'(c) * c;
        if (sq == 0) begin
            mag = lim;
        end else begin
            x = longint'(isqrt(sq << 16));
            y = longint'(a < 0 ? -a : a) << 8;
            z = 0;
            for (int i = 0; i < acctilt_pkg::CORDIC_STAGES && i < acctilt_pkg::TABLE_LEN;
                 i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(acctilt_pkg::atan_deg(5'(i)));
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(acctilt_pkg::atan_deg(5'(i)));
                end
            end
            if (z < 0) z = 0;
            mag = (z + (longint'(1) << (k - 1))) >>> k;
            if (mag > lim) mag = lim;
        end
        if (a < 0) mag = -mag;
        return mag[15:0];
    endfunction

    function automatic t_tilt predict_tilt(input logic [47:0] req);
        t_tilt       r;
        int          ax;
        int          ay;
        int          az;
        ax           = int'($signed({req[7:0], req[15:8]}));
        ay           = int'($signed({req[23:16], req[31:24]}));
        az           = int'($signed({req[39:32], req[47:40]}));
        r.pitch      = axis_angle(ax, ay, az);
        r.roll       = axis_angle(ay, ax, az);
        r.elevation  = axis_angle(az, ax, ay);
        r.degenerate = (ax == 0 && ay == 0 && az == 0);
        return r;
    endfunction

    function automatic logic [47:0] pack_sample(input logic [15:0] x, input logic [15:0] y,
                                                input logic [15:0] z);
        return {z[7:0], z[15:8], y[7:0], y[15:8], x[7:0], x[15:8]};
    endfunction

    // send one request, expecting either the given result or the prediction
    task automatic send_sample(input logic [47:0] req, input bit known, input t_tilt want);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_angles.push_back(known ? want : predict_tilt(req));
        @(negedge i_clk);
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_tilt got;
        t_tilt want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_tilt'(m_axis_tdata[48:0]);
            if (pending_angles.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result %h", got);
            end else begin
                want = pending_angles.pop_front();
                if (got !== want || m_axis_tdata[55:49] !== 7'd0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: pitch %h/%h roll %h/%h elev %h/%h degen %b/%b",
                                 want.pitch, got.pitch, want.roll, got.roll,
                                 want.elevation, got.elevation,
                                 want.degenerate, got.degenerate);
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_recv) begin
                m_axis_tready <= 1'b1;
            end else begin
                gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on accepted requests and taken results
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // directed table: x, y, z, known result flag, result
    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        bit          known;
        t_tilt       want;
    } t_row;

    t_row directed[] = '{
        // all zero: degenerate
        '{16'h0000, 16'h0000, 16'h0000, 1, '{1'b1, 16'd0, 16'd0, 16'd0}},
        // single axis: +/-90 on that axis, zero elsewhere
        '{16'h0100, 16'h0000, 16'h0000, 1, '{1'b0, 16'd0, 16'd0, 16'd23040}},
        '{16'h8000, 16'h0000, 16'h0000, 1, '{1'b0, 16'd0, 16'd0, 16'hA600}},
        '{16'h0000, 16'h7FFF, 16'h0000, 1, '{1'b0, 16'd0, 16'd23040, 16'd0}},
        '{16'h0000, 16'hFFFF, 16'h0000, 1, '{1'b0, 16'd0, 16'hA600, 16'd0}},
        '{16'h0000, 16'h0000, 16'h0001, 1, '{1'b0, 16'd23040, 16'd0, 16'd0}},
        '{16'h0000, 16'h0000, 16'h8000, 1, '{1'b0, 16'hA600, 16'd0, 16'd0}},
        // extremes and mixed signs
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0},
        '{16'h8000, 16'h8000, 16'h8000, 0, '0},
        '{16'h7FFF, 16'h8000, 16'h0001, 0, '0},
        '{16'h0001, 16'h0001, 16'h0001, 0, '0},
        '{16'hFFFF, 16'h0001, 16'hFFFF, 0, '0},
        '{16'h7FFF, 16'h0001, 16'h0000, 0, '0},
        '{16'h0001, 16'h7FFF, 16'h8000, 0, '0},
        '{16'h4000, 16'h0000, 16'h4000, 0, '0},
        '{16'h00FF, 16'hFF00, 16'h5A5A, 0, '0},
        '{16'hA5A5, 16'h0F0F, 16'hF0F0, 0, '0},
        '{16'h0000, 16'h1234, 16'hEDCC, 0, '0}
    };

    initial begin
        logic [15:0] ax[3];
        t_tilt       none;
        none          = '0;
        mismatch_cnt  = 0;
        idle_cycles   = 0;
        hold_recv     = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i])
            send_sample(pack_sample(directed[i].x, directed[i].y, directed[i].z),
                        directed[i].known, directed[i].want);
        s_axis_tvalid <= 1'b0;

        // pause until the pipe drains
        while (pending_angles.size() != 0) @(negedge i_clk);

        for (int n = 0; n < RAND_SAMPLES; n++) begin
            for (int j = 0; j < 3; j++) begin
                case ($urandom_range(0, 7))
                    0: ax[j] = 16'h0000;
                    1: ax[j] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    2: ax[j] = 16'($signed($urandom_range(0, 16)) - 8);
                    default: ax[j] = 16'($urandom);
                endcase
            end
            send_sample(pack_sample(ax[0], ax[1], ax[2]), 0, none);
        end
        s_axis_tvalid <= 1'b0;
        hold_recv     = 1;

        while (pending_angles.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (mismatch_cnt == 0 && pending_angles.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/acctilt_pkg.sv
rtl/core/acctilt_lane.sv
rtl/core/accel_tilt_angles.sv
rtl/core/acctilt_checker.sv
bench/testbench.sv
